// File: hdl/icrc_pkg.sv
// Shared types and constants for the image CRC-32 trailer check.
`timescale 1ns / 1ps
package icrc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int unsigned LEN_W = 24;
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [LEN_W-1:0] TRAILER_LEN = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_LENGTH = 8'd0,
    REG_ABS_FOLD     = 8'd1
  } cfg_reg_e;

  // Running state carried from one image byte to the next.
  typedef struct packed {
    logic [31:0]      crc;
    logic [LEN_W-1:0] pos;
    logic [31:0]      trailer;
  } icrc_state_t;

  // One check result, produced on the last byte of an image.
  typedef struct packed {
    logic        match;
    logic [31:0] computed;
    logic [31:0] stored;
  } icrc_result_t;

endpackage

// File: hdl/icrc_update.sv
// Per-byte update of the CRC state, trailer assembly and end-of-image check.
`timescale 1ns / 1ps
module icrc_update
  import icrc_pkg::*;
(
  input  icrc_state_t      state_i,
  input  logic [7:0]       data_byte_i,
  input  logic [LEN_W-1:0] image_length_i,
  input  logic             fold_en_i,
  output icrc_state_t      state_o,
  output logic             last_o,
  output icrc_result_t     result_o
);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] body_len;
  logic [LEN_W-1:0] last_pos;
  logic             in_body;
  logic [31:0]      crc_step;
  logic [31:0]      crc_bits;
  logic [31:0]      trailer_next;
  logic [31:0]      folded;

  // Bit-wise reflected CRC-32 over one byte: eight shift-and-XOR steps.
  always_comb begin
    crc_bits = {24'd0, state_i.crc[7:0] ^ data_byte_i};
    for (int k = 0; k < 8; k++) begin
      if (crc_bits[0]) begin
        crc_bits = CRC_POLY ^ (crc_bits >> 1);
      end else begin
        crc_bits = crc_bits >> 1;
      end
    end
    crc_step = crc_bits ^ (state_i.crc >> 8);
  end

  // A length below the trailer size acts as a trailer-only image.
  assign len          = (image_length_i < TRAILER_LEN) ? TRAILER_LEN : image_length_i;
  assign body_len     = len - TRAILER_LEN;
  assign last_pos     = len - LEN_W'(1);
  assign in_body      = state_i.pos < body_len;
  assign last_o       = state_i.pos >= last_pos;
  assign trailer_next = in_body ? state_i.trailer : {data_byte_i, state_i.trailer[31:8]};

  // The fold mirrors abs() on a signed word; the most negative value wraps to itself.
  assign folded = (fold_en_i && state_i.crc[31]) ? (32'd0 - state_i.crc) : state_i.crc;

  always_comb begin
    result_o.computed = folded;
    result_o.stored   = trailer_next;
    result_o.match    = (folded == trailer_next);
    if (last_o) begin
      state_o.crc     = CRC_INIT;
      state_o.pos     = '0;
      state_o.trailer = '0;
    end else begin
      state_o.crc     = in_body ? crc_step : state_i.crc;
      state_o.pos     = state_i.pos + LEN_W'(1);
      state_o.trailer = trailer_next;
    end
  end

endmodule

// File: hdl/image_crc32_trailer_check.sv
// Top level of the firmware image CRC-32 trailer check.
`timescale 1ns / 1ps
// The block checks a firmware image streamed in one byte per item, in address
// order. Register 0 holds the total image length in bytes, the four-byte CRC
// trailer included; register 1 enables the sign fold of the computed CRC. The
// body bytes go through a reflected CRC-32 (polynomial 0xEDB88320, start value
// all ones, no final XOR) while the trailer is assembled with its first byte
// least significant. On the last byte of each image one result item leaves
// the block with the match flag, the computed CRC and the stored trailer, and
// the block then re-arms itself for the next image. Bytes other than the last
// produce no result. The block takes one byte every clock cycle while no last
// byte waits: each byte sits in the input register and is folded into the CRC
// state on its way out, and a result goes from there to the output register.
// The rate is set by the byte-wide CRC update, which closes on itself through
// the state register. The output register holds a result until it is taken
// while further bytes keep flowing in; only a last byte that finds the output
// register still full waits. Configuration writes are always accepted and
// should only be made while no item is in flight.
module image_crc32_trailer_check
  import icrc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 crc_match_o,
  output logic [31:0]          computed_crc_o,
  output logic [31:0]          stored_crc_o
);

  logic [LEN_W-1:0] len_q;
  logic             fold_q;

  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;

  icrc_state_t      state_q;
  icrc_state_t      state_d;
  logic             upd_last;
  icrc_result_t     upd_res;

  logic             out_valid_q;
  icrc_result_t     out_q;

  logic             out_free;
  logic             advance;

  // Configuration registers. Writes to an unknown index are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      fold_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_LENGTH: len_q  <= cfg_data_i;
        REG_ABS_FOLD:     fold_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The byte in the input register is processed when it leaves. Only the last
  // byte of an image needs room in the output register; all others go at once.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (!upd_last || out_free);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
    end
  end

  icrc_update u_update (
    .state_i        (state_q),
    .data_byte_i    (s1_byte_q),
    .image_length_i (len_q),
    .fold_en_i      (fold_q),
    .state_o        (state_d),
    .last_o         (upd_last),
    .result_o       (upd_res)
  );

  // Running CRC, byte position and trailer word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.crc     <= CRC_INIT;
      state_q.pos     <= '0;
      state_q.trailer <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register: loaded by the last byte of an image, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && upd_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && upd_last) begin
      out_q <= upd_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign crc_match_o    = out_q.match;
  assign computed_crc_o = out_q.computed;
  assign stored_crc_o   = out_q.stored;

  // The match flag always agrees with the two words it reports on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (crc_match_o == (computed_crc_o == stored_crc_o)))
    else $error("match flag disagrees with reported words");

  // Ending an image re-arms the running state for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && upd_last) |=>
      (state_q.crc == CRC_INIT && state_q.pos == '0 && state_q.trailer == '0))
    else $error("state not re-armed after the last byte");

  // With the fold on, a reported CRC has bit 31 clear unless it is the wrapped value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fold_q) |->
      (!computed_crc_o[31] || computed_crc_o == 32'h8000_0000))
    else $error("folded CRC still negative");

  // Input is only held off while a byte waits that cannot move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && upd_last && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

  // A byte that ends no image never touches the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(advance && upd_last)) |=> !out_valid_o)
    else $error("result produced without a last byte");

endmodule

// File: tb/sv/tb_image_crc32_trailer_check.sv
// Self-checking testbench for the firmware image CRC-32 trailer check.
`timescale 1ns / 1ps
// Image bytes are fed through the valid/ready input channel by a clocked
// driver that pops them from a queue of pending bytes, and results are taken
// by a receiver that stalls at random. A clocked monitor watches every
// handshake on the rising edge. Each accepted byte is run through a local
// model of the checker (running CRC, byte position, trailer word and a copy
// of both registers). Any result it produces goes to the back of a queue of
// expected results, and every result the block hands out is compared field
// by field with the front of that queue. The stimulus starts with a handful
// of directed images and then runs phases of random images, each phase with
// its own image length, fold setting and idling pattern.
module tb_image_crc32_trailer_check;
  import icrc_pkg::*;

  localparam int N_RANDOM_BYTES = 1250;
  localparam int PRESSURE_HOLD = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  typedef enum {IMG_GOOD, IMG_FLIPPED, IMG_NOISE} image_kind_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 crc_match;
  logic [31:0]          computed_crc;
  logic [31:0]          stored_crc;

  image_crc32_trailer_check dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .crc_match_o    (crc_match),
    .computed_crc_o (computed_crc),
    .stored_crc_o   (stored_crc)
  );

  // Bytes waiting to be offered, and the check results still owed by the block.
  logic [7:0]   pend_q[$];
  icrc_result_t crc_expect_q[$];

  // Local copy of the checker: registers and per-image state at reset values.
  logic [LEN_W-1:0] cfg_len = LEN_RESET;
  logic             cfg_fold = 1'b1;
  logic [31:0]      img_crc = CRC_INIT;
  logic [LEN_W-1:0] img_pos = '0;
  logic [31:0]      img_trailer = '0;

  int n_errors = 0;
  int n_items = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  int pressure_req = 0;
  int pressure_seen = 0;
  logic byte_taken = 1'b0;

  initial forever #1 clk = ~clk;

  // A hard ceiling on the run, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // One byte through the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c ^ (crc >> 8);
  endfunction

  // Takes one accepted image byte; returns 1 and the result when it ends an image.
  // A length below the trailer size behaves as a trailer-only image, and a length
  // changed part way through is judged against the position already reached.
  function automatic bit absorb_byte(input logic [7:0] b, output icrc_result_t res);
    logic [LEN_W-1:0] eff;
    logic [31:0]      crc;
    res = '0;
    eff = (cfg_len < TRAILER_LEN) ? TRAILER_LEN : cfg_len;
    if (img_pos < eff - TRAILER_LEN) img_crc = crc_step(img_crc, b);
    else img_trailer = {b, img_trailer[31:8]};
    if (img_pos >= eff - 24'd1) begin
      crc = img_crc;
      // The fold is a plain two's complement negation, so 0x80000000 maps to itself.
      if (cfg_fold && crc[31]) crc = -crc;
      res.match    = (crc == img_trailer);
      res.computed = crc;
      res.stored   = img_trailer;
      img_crc      = CRC_INIT;
      img_pos      = '0;
      img_trailer  = '0;
      return 1'b1;
    end
    img_pos = img_pos + 24'd1;
    return 1'b0;
  endfunction

  // Gap length: a gap in idle_pct percent of the calls, mostly short when there is one.
  function automatic int pick_gap(input int idle_pct);
    int r;
    if ($urandom_range(99) >= idle_pct) return 0;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void offer(input logic [7:0] b);
    pend_q.push_back(b);
    n_items++;
  endfunction

  // Four body bytes that walk the CRC from one value to any other: the
  // table indices are found backwards from the target, then each byte is
  // chosen so that the forward step lands on its index.
  function automatic void offer_forged(input logic [31:0] from_crc, input logic [31:0] to_crc);
    logic [7:0]  idx [4];
    logic [31:0] x;
    logic [31:0] c;
    logic [31:0] t;
    logic [7:0]  b;
    x = to_crc;
    for (int k = 3; k >= 0; k--) begin
      for (int i = 0; i < 256; i++) begin
        t = crc_step(32'd0, 8'(i));
        if (t[31:24] == x[31:24]) idx[k] = 8'(i);
      end
      x = (x ^ crc_step(32'd0, idx[k])) << 8;
    end
    c = from_crc;
    for (int k = 0; k < 4; k++) begin
      b = c[7:0] ^ idx[k];
      offer(b);
      c = crc_step(c, b);
    end
  endfunction

  // One whole image of eff bytes, with a trailer that is right, off by one
  // bit, or random, judged against the current fold setting.
  function automatic void offer_image(input int eff, input image_kind_e kind);
    logic [31:0] c;
    logic [31:0] trailer;
    logic [7:0]  b;
    c = CRC_INIT;
    for (int k = 0; k < eff - int'(TRAILER_LEN); k++) begin
      b = 8'($urandom);
      offer(b);
      c = crc_step(c, b);
    end
    if (cfg_fold && c[31]) c = -c;
    case (kind)
      IMG_GOOD:    trailer = c;
      IMG_FLIPPED: trailer = c ^ (32'd1 << $urandom_range(31));
      default:     trailer = $urandom;
    endcase
    for (int k = 0; k < 4; k++) offer(trailer[8*k +: 8]);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Returns once every byte is in and every owed result has come out, and a
  // byte still sitting in the input register has had time to leave it.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || crc_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: holds an offered item until it is taken, then idles for the gap
  // chosen when it was offered before moving on to the next pending byte.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !byte_taken) begin
        // still waiting for the handshake
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pend_q.size() != 0) begin
        in_valid  <= 1'b1;
        data_byte <= pend_q.pop_front();
        in_gap    <= pick_gap(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks
  // for one, so that the output register stays full and the input backs up.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (pressure_seen != pressure_req) begin
      pressure_seen <= pressure_req;
      hold_cnt      <= PRESSURE_HOLD;
      out_ready     <= 1'b0;
    end else if (stall_cnt > 0) begin
      out_ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_ready <= 1'b1;
      stall_cnt <= pick_gap(out_idle_pct);
    end
  end

  // Monitor: checks results first, then folds in the byte and any register
  // write taken on this same edge.
  always @(posedge clk) begin : watch
    icrc_result_t want;
    icrc_result_t seen;
    byte_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.match    = crc_match;
        seen.computed = computed_crc;
        seen.stored   = stored_crc;
        if (crc_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected: match %b computed %h stored %h",
                   $time, seen.match, seen.computed, seen.stored);
          n_errors++;
        end else begin
          want = crc_expect_q.pop_front();
          if (seen.match !== want.match) begin
            $display("%0t: crc_match expected %b got %b", $time, want.match, seen.match);
            n_errors++;
          end
          if (seen.computed !== want.computed) begin
            $display("%0t: computed_crc expected %h got %h", $time, want.computed,
                     seen.computed);
            n_errors++;
          end
          if (seen.stored !== want.stored) begin
            $display("%0t: stored_crc expected %h got %h", $time, want.stored, seen.stored);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (absorb_byte(data_byte, want)) crc_expect_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_LENGTH: cfg_len = cfg_data;
          REG_ABS_FOLD:     cfg_fold = cfg_data[0];
          default:          ; // unknown register indexes are ignored
        endcase
      end
    end
  end

  initial begin : stimulus
    int eff;
    int n_img;
    int r;
    bit pressure;
    image_kind_e kind;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_pct  = 30;
    out_idle_pct = 30;

    // Reset settings: trailer-only image, CRC stays at all ones and folds to 1.
    offer(8'h01); offer(8'h00); offer(8'h00); offer(8'h00);
    drain();

    // Writes to unused indexes must change nothing; the fold register only
    // looks at bit 0. A zero length still means a trailer-only image.
    write_reg(REG_UNUSED_LOW, 24'hFFFFFF);
    write_reg(REG_UNUSED_TOP, 24'hFFFFFF);
    write_reg(REG_IMAGE_LENGTH, 24'd0);
    write_reg(REG_ABS_FOLD, 24'hFFFFFE);
    offer(8'hFF); offer(8'hFF); offer(8'hFF); offer(8'hFF);
    drain();

    // Length just below the trailer size, fold on, trailer that does not match.
    write_reg(REG_IMAGE_LENGTH, 24'd3);
    write_reg(REG_ABS_FOLD, 24'd1);
    offer(8'h00); offer(8'h00); offer(8'h00); offer(8'h00);
    drain();

    // A body whose CRC is exactly 0x80000000, which the fold leaves alone.
    write_reg(REG_IMAGE_LENGTH, 24'd8);
    offer_forged(CRC_INIT, 32'h8000_0000);
    offer(8'h00); offer(8'h00); offer(8'h00); offer(8'h80);
    drain();

    // Largest length, then shortened part way through the image: the byte
    // at the new last position closes it.
    write_reg(REG_IMAGE_LENGTH, 24'hFFFFFF);
    offer(8'h00); offer(8'hFF); offer(8'h5A);
    drain();
    write_reg(REG_IMAGE_LENGTH, 24'd5);
    offer(8'hA5); offer(8'h3C);
    drain();

    // Random phases, each with its own settings and idling pattern.
    n_items = 0;
    for (int phase = 0; n_items < N_RANDOM_BYTES; phase++) begin
      pressure = (phase % 7 == 2);
      if (pressure) begin
        write_reg(REG_IMAGE_LENGTH, LEN_W'($urandom_range(4, 6)));
      end else if ($urandom_range(3) != 0) begin
        r = $urandom_range(99);
        if (r < 5) write_reg(REG_IMAGE_LENGTH, LEN_W'($urandom_range(0, 3)));
        else if (r < 60) write_reg(REG_IMAGE_LENGTH, LEN_W'($urandom_range(4, 24)));
        else if (r < 88) write_reg(REG_IMAGE_LENGTH, LEN_W'($urandom_range(25, 64)));
        else write_reg(REG_IMAGE_LENGTH, LEN_W'($urandom_range(65, 300)));
      end
      if ($urandom_range(2) == 0) write_reg(REG_ABS_FOLD, LEN_W'($urandom));
      if ($urandom_range(9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)), LEN_W'($urandom));

      if ($urandom_range(3) == 0) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(10, 60);
        out_idle_pct = $urandom_range(10, 60);
      end

      eff = (cfg_len < TRAILER_LEN) ? int'(TRAILER_LEN) : int'(cfg_len);

      // A previous phase may have stopped mid-image: finish that image first
      // so that the new ones line up with the configured length.
      if (img_pos != '0) begin
        n_img = (int'(img_pos) >= eff - 1) ? 1 : eff - int'(img_pos);
        for (int k = 0; k < n_img; k++) offer(8'($urandom));
      end

      n_img = pressure ? 40 : $urandom_range(1, (100 / eff > 1) ? 100 / eff : 1);
      for (int k = 0; k < n_img; k++) begin
        r = $urandom_range(99);
        kind = (r < 75) ? IMG_GOOD : (r < 90) ? IMG_FLIPPED : IMG_NOISE;
        offer_image(eff, kind);
      end
      // Sometimes leave an image unfinished, so the next length change lands mid-image.
      if (!pressure && $urandom_range(4) == 0) begin
        n_img = $urandom_range(1, eff - 1);
        for (int k = 0; k < n_img; k++) offer(8'($urandom));
      end
      if (pressure) pressure_req++;
      drain();
    end

    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/icrc_pkg.sv
hdl/icrc_update.sv
hdl/image_crc32_trailer_check.sv
tb/sv/tb_image_crc32_trailer_check.sv
